[hw/rtl/pdlf_pkg.sv]
// Shared types, constants and helpers of the duty-cycle fade engine.
package pdlf_pkg;

  localparam int unsigned DUTY_W    = 20;
  localparam int unsigned MS_W      = 24;
  localparam int unsigned PCT_W     = 14;
  localparam int unsigned BITS_W    = 5;
  localparam int unsigned PROD_W    = DUTY_W + MS_W;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W + 1);

  localparam logic [PCT_W-1:0]  PCT_FULL        = PCT_W'(10000);
  localparam logic [BITS_W-1:0] DUTY_BITS_RESET = BITS_W'(8);
  localparam logic [BITS_W-1:0] DUTY_BITS_MIN   = BITS_W'(1);
  localparam logic [BITS_W-1:0] DUTY_BITS_MAX   = BITS_W'(DUTY_W);

  typedef enum logic [1:0] {
    REQ_SET_DUTY = 2'd0,
    REQ_SET_PCT  = 2'd1,
    REQ_FADE     = 2'd2,
    REQ_TICK     = 2'd3
  } pdlf_req_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic direct_set;
    logic mul_go;
    logic div_go;
    logic pct_apply;
    logic tick_adv;
    logic tick_end;
    logic interp_apply;
    logic idle_tick;
    logic out_load;
  } pdlf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    pdlf_req_e req;
    logic      fade_active;
    logic      tick_done;
    logic      div_done;
  } pdlf_sts_t;

  // Largest duty for a resolution, with the resolution clamped to 1..20 bits.
  function automatic logic [DUTY_W-1:0] pdlf_max_duty(input logic [BITS_W-1:0] bits);
    logic [BITS_W-1:0] b;
    logic [DUTY_W:0]   one_hot;
    b = bits;
    if (b < DUTY_BITS_MIN) b = DUTY_BITS_MIN;
    if (b > DUTY_BITS_MAX) b = DUTY_BITS_MAX;
    one_hot = (DUTY_W+1)'(1) << b;
    return DUTY_W'(one_hot - (DUTY_W+1)'(1));
  endfunction

endpackage

[hw/rtl/pdlf_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
module pdlf_divider
  import pdlf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [MS_W-1:0]   divisor_i,
  output logic              done_o,
  output logic [PROD_W-1:0] quotient_o
);

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PROD_W-1:0]    quo_q, quo_d;
  logic [MS_W-1:0]      rem_q, rem_d;
  logic [MS_W-1:0]      dsr_q, dsr_d;
  logic [MS_W:0]        shifted;
  logic [MS_W:0]        trial;
  logic                 fits;

  assign shifted = {rem_q, quo_q[PROD_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(PROD_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits MS_W bits.
      rem_d = fits ? trial[MS_W-1:0] : shifted[MS_W-1:0];
      quo_d = {quo_q[PROD_W-2:0], fits};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = !busy_q;
  assign quotient_o = quo_q;

endmodule

[hw/rtl/pdlf_datapath.sv]
// Datapath: duty state, shared multiplier, divider and result register.
module pdlf_datapath
  import pdlf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdlf_cmd_t         cmd_i,
  output pdlf_sts_t         sts_o,
  input  logic              cfg_we_i,
  input  logic [BITS_W-1:0] cfg_duty_bits_i,
  input  logic [1:0]        req_type_i,
  input  logic [DUTY_W-1:0] duty_value_i,
  input  logic [PCT_W-1:0]  percent_hundredths_i,
  input  logic [MS_W-1:0]   fade_ms_i,
  output logic [DUTY_W-1:0] duty_o,
  output logic              fading_o,
  output logic              wrote_o
);

  logic [BITS_W-1:0] duty_bits_q;
  logic [DUTY_W-1:0] current_q, start_q, target_q;
  logic [MS_W-1:0]   elapsed_q, duration_q;
  logic              fade_q, wrote_q;

  pdlf_req_e         req_q;
  logic [DUTY_W-1:0] dv_q;
  logic [PCT_W-1:0]  pct_q;
  logic [MS_W-1:0]   ms_q;
  logic [PROD_W-1:0] prod_q;

  logic [DUTY_W-1:0] duty_out_q;
  logic              fading_out_q, wrote_out_q;

  logic [DUTY_W-1:0] max_w;
  logic [PCT_W-1:0]  pct_sat;
  logic              is_tick, up;
  logic [DUTY_W-1:0] diff;
  logic [DUTY_W-1:0] mul_a;
  logic [MS_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [MS_W-1:0]   bias;
  logic [PROD_W-1:0] div_dividend;
  logic [MS_W-1:0]   div_divisor;
  logic              div_done;
  logic [PROD_W-1:0] div_quo;
  logic [DUTY_W-1:0] quo;
  logic [DUTY_W-1:0] set_val;
  logic [MS_W-1:0]   elapsed_inc;

  assign max_w   = pdlf_max_duty(duty_bits_q);
  assign pct_sat = (pct_q > PCT_FULL) ? PCT_FULL : pct_q;
  assign is_tick = (req_q == REQ_TICK);
  assign up      = target_q >= start_q;
  assign diff    = up ? (target_q - start_q) : (start_q - target_q);

  // One multiplier serves both the percent scaling and the fade step.
  assign mul_a = is_tick ? diff : max_w;
  assign mul_b = is_tick ? elapsed_q : MS_W'(pct_sat);
  assign mul_p = mul_a * mul_b;

  // A falling fade rounds the step up, so the duty is floored overall.
  assign bias         = (is_tick && !up) ? (duration_q - MS_W'(1)) : '0;
  assign div_dividend = prod_q + PROD_W'(bias);
  assign div_divisor  = is_tick ? duration_q : MS_W'(PCT_FULL);
  assign quo          = div_quo[DUTY_W-1:0];

  assign set_val     = (dv_q > max_w) ? max_w : dv_q;
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : (elapsed_q + MS_W'(1));

  pdlf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_bits_q <= DUTY_BITS_RESET;
      current_q   <= '0;
      start_q     <= '0;
      target_q    <= '0;
      elapsed_q   <= '0;
      duration_q  <= '0;
      fade_q      <= 1'b0;
      wrote_q     <= 1'b0;
    end else begin
      if (cfg_we_i) duty_bits_q <= cfg_duty_bits_i;
      if (cmd_i.direct_set) begin
        current_q <= set_val;
        fade_q    <= 1'b0;
        wrote_q   <= 1'b1;
      end
      if (cmd_i.pct_apply) begin
        if (req_q == REQ_SET_PCT) begin
          current_q <= (quo > max_w) ? max_w : quo;
          fade_q    <= 1'b0;
          wrote_q   <= 1'b1;
        end else begin
          target_q <= quo;
          wrote_q  <= 1'b0;
          if (quo == current_q) begin
            fade_q <= 1'b0;
          end else begin
            start_q    <= current_q;
            duration_q <= ms_q;
            elapsed_q  <= '0;
            fade_q     <= 1'b1;
          end
        end
      end
      if (cmd_i.tick_adv) elapsed_q <= elapsed_inc;
      if (cmd_i.tick_end) begin
        current_q <= target_q;
        fade_q    <= 1'b0;
        wrote_q   <= 1'b1;
      end
      if (cmd_i.interp_apply) begin
        current_q <= up ? (start_q + quo) : (start_q - quo);
        wrote_q   <= 1'b1;
      end
      if (cmd_i.idle_tick) wrote_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= pdlf_req_e'(req_type_i);
      dv_q  <= duty_value_i;
      pct_q <= percent_hundredths_i;
      ms_q  <= fade_ms_i;
    end
    if (cmd_i.mul_go) prod_q <= mul_p;
    if (cmd_i.out_load) begin
      duty_out_q   <= current_q;
      fading_out_q <= fade_q;
      wrote_out_q  <= wrote_q;
    end
  end

  assign sts_o.req         = req_q;
  assign sts_o.fade_active = fade_q;
  assign sts_o.tick_done   = elapsed_q >= duration_q;
  assign sts_o.div_done    = div_done;

  assign duty_o   = duty_out_q;
  assign fading_o = fading_out_q;
  assign wrote_o  = wrote_out_q;

endmodule

[hw/rtl/pdlf_ctrl.sv]
// Controller: sequences one item through the datapath and owns the result valid.
module pdlf_ctrl
  import pdlf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  pdlf_sts_t sts_i,
  output pdlf_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_TICK_CHK,
    S_MUL_WAIT,
    S_DIV,
    S_APPLY,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.req)
          REQ_SET_DUTY: begin
            cmd_o.direct_set = 1'b1;
            state_d          = S_RESULT;
          end
          REQ_SET_PCT, REQ_FADE: begin
            cmd_o.mul_go = 1'b1;
            state_d      = S_MUL_WAIT;
          end
          REQ_TICK: begin
            if (sts_i.fade_active) begin
              cmd_o.tick_adv = 1'b1;
              state_d        = S_TICK_CHK;
            end else begin
              cmd_o.idle_tick = 1'b1;
              state_d         = S_RESULT;
            end
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_TICK_CHK: begin
        if (sts_i.tick_done) begin
          cmd_o.tick_end = 1'b1;
          state_d        = S_RESULT;
        end else begin
          cmd_o.mul_go = 1'b1;
          state_d      = S_MUL_WAIT;
        end
      end
      S_MUL_WAIT: begin
        cmd_o.div_go = 1'b1;
        state_d      = S_DIV;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_APPLY;
      end
      S_APPLY: begin
        if (sts_i.req == REQ_TICK) cmd_o.interp_apply = 1'b1;
        else                       cmd_o.pct_apply    = 1'b1;
        state_d = S_RESULT;
      end
      S_RESULT: begin
        // Wait until the result register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load)             out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/pwm_duty_linear_fade_unit.sv]
// Top level of the duty-cycle engine with timed linear fades.
// The block takes one item at a time. A set-duty item or a tick that finds no
// fade running has its result loaded straight after dispatch, and a tick that
// ends a fade after the tick check. A set-percent item or a fade item passes
// the multiply, divide and apply states, a tick inside a running fade the tick
// check first; the serial divider produces one of its 44 quotient bits per cycle.
// The input reopens in the cycle after the result is loaded, so the next item
// is accepted while an earlier result still waits to be taken; a result that
// finds the register still full waits for it to be taken. The resolution
// register is written through its own channel, always ready, and applies to
// requests that follow; stored duties are kept when it changes.
module pwm_duty_linear_fade_unit
  import pdlf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [BITS_W-1:0] cfg_duty_bits_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [DUTY_W-1:0] duty_value_i,
  input  logic [PCT_W-1:0]  percent_hundredths_i,
  input  logic [MS_W-1:0]   fade_ms_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DUTY_W-1:0] duty_o,
  output logic              fading_o,
  output logic              wrote_o
);

  pdlf_cmd_t cmd;
  pdlf_sts_t sts;

  assign cfg_ready_o = 1'b1;

  pdlf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pdlf_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_we_i             (cfg_valid_i && cfg_ready_o),
    .cfg_duty_bits_i      (cfg_duty_bits_i),
    .req_type_i           (req_type_i),
    .duty_value_i         (duty_value_i),
    .percent_hundredths_i (percent_hundredths_i),
    .fade_ms_i            (fade_ms_i),
    .duty_o               (duty_o),
    .fading_o             (fading_o),
    .wrote_o              (wrote_o)
  );

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten while full");

  // The divider is only started when it is idle.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_go |-> sts.div_done)
    else $error("divider started while busy");

  // An accepted item closes the input until its result is loaded.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item accepted while one is in work");

  // A fade interpolation or a percent result is only applied after the divider has finished.
  a_apply_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.interp_apply || cmd.pct_apply) |-> sts.div_done)
    else $error("quotient used before the divider finished");

endmodule

[test/pwm_duty_linear_fade_unit_test.sv]
// Self-checking testbench for the duty-cycle engine with timed linear fades.
module pwm_duty_linear_fade_unit_test
  import pdlf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              fading;
    logic              wrote;
  } duty_report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [BITS_W-1:0] cfg_duty_bits_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [1:0]        req_type_i = '0;
  logic [DUTY_W-1:0] duty_value_i = '0;
  logic [PCT_W-1:0]  percent_hundredths_i = '0;
  logic [MS_W-1:0]   fade_ms_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [DUTY_W-1:0] duty_o;
  logic              fading_o;
  logic              wrote_o;

  // Predicted engine state, updated on every accepted item and register write.
  logic [BITS_W-1:0] res_bits     = DUTY_BITS_RESET;
  logic [DUTY_W-1:0] cur_duty     = '0;
  logic [DUTY_W-1:0] ramp_from    = '0;
  logic [DUTY_W-1:0] ramp_to      = '0;
  logic [MS_W-1:0]   ramp_elapsed = '0;
  logic [MS_W-1:0]   ramp_len     = '0;
  logic              ramp_on      = 1'b0;

  duty_report_t pending_reports[$];
  int unsigned  error_count = 0;
  bit           gaps_on = 1'b1;
  bit           hold_pending = 1'b0;
  int unsigned  hold_left = 0;

  pwm_duty_linear_fade_unit i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_duty_bits_i      (cfg_duty_bits_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .req_type_i           (req_type_i),
    .duty_value_i         (duty_value_i),
    .percent_hundredths_i (percent_hundredths_i),
    .fade_ms_i            (fade_ms_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .duty_o               (duty_o),
    .fading_o             (fading_o),
    .wrote_o              (wrote_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(10ms);
    $display("pwm_duty_linear_fade_unit_test: errors");
    $finish;
  end

  function automatic logic [DUTY_W-1:0] full_scale(input logic [BITS_W-1:0] bits);
    int unsigned b;
    b = bits;
    if (b < 1) b = 1;
    if (b > DUTY_W) b = DUTY_W;
    return DUTY_W'((1 << b) - 1);
  endfunction

  function automatic logic [DUTY_W-1:0] pct_to_duty(input logic [PCT_W-1:0] pct,
                                                    input logic [BITS_W-1:0] bits);
    longint unsigned p;
    longint unsigned top;
    p = pct;
    if (p > PCT_FULL) p = PCT_FULL;
    top = full_scale(bits);
    return DUTY_W'((p * top) / PCT_FULL);
  endfunction

  // Both directions round the ramp point down: rising ramps toward the start duty, falling ones toward the target.
  function automatic logic [DUTY_W-1:0] ramp_point();
    longint unsigned span;
    longint unsigned e;
    longint unsigned d;
    e = ramp_elapsed;
    d = ramp_len;
    if (ramp_to >= ramp_from) begin
      span = ramp_to - ramp_from;
      return ramp_from + DUTY_W'((span * e) / d);
    end else begin
      span = ramp_from - ramp_to;
      return ramp_from - DUTY_W'((span * e + d - 1) / d);
    end
  endfunction

  function automatic duty_report_t advance_engine(input pdlf_req_e req,
                                                  input logic [DUTY_W-1:0] dv,
                                                  input logic [PCT_W-1:0] pct,
                                                  input logic [MS_W-1:0] ms);
    logic [DUTY_W-1:0] v;
    logic              wrote;
    wrote = 1'b0;
    case (req)
      REQ_SET_DUTY, REQ_SET_PCT: begin
        v = (req == REQ_SET_DUTY) ? dv : pct_to_duty(pct, res_bits);
        if (v > full_scale(res_bits)) v = full_scale(res_bits);
        ramp_on = 1'b0;
        cur_duty = v;
        wrote = 1'b1;
      end
      REQ_FADE: begin
        ramp_to = pct_to_duty(pct, res_bits);
        if (ramp_to == cur_duty) begin
          ramp_on = 1'b0;
        end else begin
          ramp_from = cur_duty;
          ramp_len = ms;
          ramp_elapsed = '0;
          ramp_on = 1'b1;
        end
      end
      default: begin
        if (ramp_on) begin
          if (ramp_elapsed != '1) ramp_elapsed = ramp_elapsed + 1'b1;
          if (ramp_elapsed >= ramp_len) begin
            cur_duty = ramp_to;
            ramp_on = 1'b0;
          end else begin
            cur_duty = ramp_point();
          end
          wrote = 1'b1;
        end
      end
    endcase
    return '{duty: cur_duty, fading: ramp_on, wrote: wrote};
  endfunction

  task automatic report_mismatch(input string what, input duty_report_t want,
                                 input duty_report_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected duty %0d fading %0d wrote %0d, got duty %0d fading %0d wrote %0d",
               $realtime, what, want.duty, want.fading, want.wrote,
               got.duty, got.fading, got.wrote);
    end
  endtask

  // Prediction on each accepted item and register write, and the result check.
  always @(posedge clk_i) begin
    duty_report_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) res_bits = cfg_duty_bits_i;
      if (in_valid_i && in_ready_o) begin
        pending_reports.push_back(advance_engine(pdlf_req_e'(req_type_i), duty_value_i,
                                                 percent_hundredths_i, fade_ms_i));
      end
      if (out_valid_o && out_ready_i) begin
        got = '{duty: duty_o, fading: fading_o, wrote: wrote_o};
        if (pending_reports.size() == 0) begin
          report_mismatch("unexpected result", '0, got);
        end else if (got !== pending_reports[0]) begin
          report_mismatch("result mismatch", pending_reports[0], got);
          void'(pending_reports.pop_front());
        end else begin
          void'(pending_reports.pop_front());
        end
      end
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk_i) begin
    if (hold_pending) begin
      hold_left = 400;
      hold_pending = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !(gaps_on && $urandom_range(99) < 12);
    end
  end

  // Starts and ends at a falling edge; valid stays high after acceptance so
  // that back-to-back items keep it asserted.
  task automatic send_request(input pdlf_req_e req, input logic [DUTY_W-1:0] dv,
                              input logic [PCT_W-1:0] pct, input logic [MS_W-1:0] ms);
    while (gaps_on && $urandom_range(99) < 12) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = req;
    duty_value_i = dv;
    percent_hundredths_i = pct;
    fade_ms_i = ms;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_resolution(input logic [BITS_W-1:0] bits);
    wait_drained();
    cfg_duty_bits_i = bits;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [PCT_W-1:0] random_pct();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return PCT_FULL;
    if (r < 30) return PCT_W'($urandom_range(16383));
    return PCT_W'($urandom_range(PCT_FULL));
  endfunction

  task automatic check_directed_requests();
    send_request(REQ_TICK, '1, '1, '1);           // tick right after reset, idle
    send_request(REQ_SET_DUTY, '0, '0, '0);
    send_request(REQ_SET_DUTY, '1, '0, '0);       // clamped to the maximum
    send_request(REQ_SET_DUTY, 20'd100, '0, '0);
    send_request(REQ_SET_PCT, '0, '0, '0);
    send_request(REQ_SET_PCT, '0, PCT_FULL, '0);
    send_request(REQ_SET_PCT, '0, '1, '0);        // saturates at full duty
    send_request(REQ_SET_PCT, '0, 14'd5000, '0);
    send_request(REQ_FADE, '0, 14'd5000, 24'd9);  // target equals current duty
    send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_FADE, '0, '0, 24'd4);        // falling fade
    repeat (5) send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_FADE, '0, 14'd7000, '0);     // zero duration
    send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_FADE, '0, PCT_FULL, 24'd10);
    repeat (2) send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_FADE, '0, 14'd100, 24'd3);   // restart from the running duty
    repeat (4) send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_FADE, '0, PCT_FULL, '1);
    send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_SET_DUTY, 20'd17, '0, '0);   // cancels the fade
  endtask

  task automatic check_resolution_sweep();
    write_resolution(5'd20);
    send_request(REQ_SET_DUTY, '1, '0, '0);
    write_resolution(5'd4);
    // The stored duty stays above the new maximum until something writes it.
    send_request(REQ_TICK, '0, '0, '0);
    send_request(REQ_FADE, '0, 14'd5000, 24'd3);
    repeat (4) send_request(REQ_TICK, '0, '0, '0);
    write_resolution(5'd0);
    send_request(REQ_SET_PCT, '0, PCT_FULL, '0);
    send_request(REQ_SET_DUTY, 20'd5, '0, '0);
    write_resolution(5'd31);
    send_request(REQ_SET_DUTY, '1, '0, '0);
    send_request(REQ_FADE, '0, '0, 24'd2);
    repeat (3) send_request(REQ_TICK, '0, '0, '0);
    write_resolution(DUTY_BITS_RESET);
  endtask

  task automatic check_backpressure();
    gaps_on = 1'b0;
    @(posedge clk_i);
    hold_pending = 1'b1;
    @(negedge clk_i);
    send_request(REQ_FADE, '0, 14'd9000, 24'd12);
    repeat (20) begin
      if ($urandom_range(3) == 0) send_request(REQ_SET_DUTY, 20'($urandom()), '0, '0);
      else send_request(REQ_TICK, 20'($urandom()), 14'($urandom()), 24'($urandom()));
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic check_random_fades();
    logic [BITS_W-1:0] phase_bits[7];
    int unsigned       sent;
    int unsigned       ticks;
    int unsigned       r;
    logic [MS_W-1:0]   ms;
    phase_bits = '{5'd8, 5'd1, 5'd20, 5'd0, 5'd31, 5'd12, 5'd8};
    phase_bits[6] = BITS_W'($urandom_range(31));
    for (int ph = 0; ph < 7; ph++) begin
      write_resolution(phase_bits[ph]);
      gaps_on = (ph != 2);
      sent = 0;
      while (sent < 245) begin
        r = $urandom_range(99);
        if (r < 50) begin
          ms = ($urandom_range(99) < 5) ? MS_W'($urandom()) : MS_W'($urandom_range(40));
          send_request(REQ_FADE, 20'($urandom()), random_pct(), ms);
          ticks = $urandom_range(ms > 40 ? 6 : ms + 3);
          repeat (ticks) send_request(REQ_TICK, 20'($urandom()), 14'($urandom()),
                                      24'($urandom()));
          sent += 1 + ticks;
        end else if (r < 70) begin
          if ($urandom_range(1) == 0) send_request(REQ_SET_DUTY, 20'($urandom()),
                                                   14'($urandom()), 24'($urandom()));
          else send_request(REQ_SET_DUTY, 20'($urandom_range(full_scale(res_bits))),
                            14'($urandom()), 24'($urandom()));
          sent++;
        end else if (r < 90) begin
          send_request(REQ_SET_PCT, 20'($urandom()), random_pct(), 24'($urandom()));
          sent++;
        end else begin
          // Stray tick, mostly ignored by an idle engine.
          send_request(REQ_TICK, 20'($urandom()), 14'($urandom()), 24'($urandom()));
        end
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    check_directed_requests();
    check_resolution_sweep();
    check_backpressure();
    check_random_fades();
    wait_drained();
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("pwm_duty_linear_fade_unit_test: clean");
    end else begin
      $display("pwm_duty_linear_fade_unit_test: errors");
    end
    $finish;
  end

endmodule
